// ===== hdl/qwd_pkg.sv =====
// Shared types and constants for the quiet window detector.
// No dependencies; every other file refers to this package by scoped name.
package qwd_pkg;

    localparam int WINDOW_MAX    = 1024;
    localparam int SAMPLE_BITS   = 16;
    localparam int INDEX_BITS    = 20;
    localparam int WLEN_BITS     = 11;
    localparam int THR_BITS      = 16;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 16;
    localparam int PTR_BITS      = $clog2(WINDOW_MAX);
    localparam int CNT_BITS      = PTR_BITS + 1;

    // Range check adds min and threshold; the compare must cover that and positions
    localparam int SUM_BITS = ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 1;
    localparam int CMP_BITS = (INDEX_BITS > SUM_BITS) ? INDEX_BITS : SUM_BITS;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEN = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD  = CFG_IDX_BITS'(1);

    // One deque entry: sample value and its 1-based position
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] val;
        logic [INDEX_BITS-1:0]  pos;
    } entry_t;

    // Operations of the shared compare unit
    typedef enum logic [1:0] {
        CMP_EXPIRE,
        CMP_DROP_MAX,
        CMP_DROP_MIN,
        CMP_RANGE
    } cmp_op_t;

    // Operands handed to the compare unit
    typedef struct packed {
        cmp_op_t                op;
        entry_t                 entry_a;
        entry_t                 entry_b;
        logic [SAMPLE_BITS-1:0] sample;
        logic [INDEX_BITS-1:0]  cut;
        logic [THR_BITS-1:0]    threshold;
    } cmp_req_t;

endpackage

// ===== hdl/qwd_if.sv =====
// Valid/ready channel interfaces of the quiet window detector.
// Depends on qwd_pkg for field widths.

// Sample item channel
interface qwd_sample_if;
    logic                            valid;
    logic                            ready;
    logic [qwd_pkg::SAMPLE_BITS-1:0] sample;
    logic                            last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// Result item channel
interface qwd_result_if;
    logic                           valid;
    logic                           ready;
    logic [qwd_pkg::INDEX_BITS-1:0] start_index;
    logic                           none_found;

    modport source (output valid, output start_index, output none_found, input ready);
    modport sink   (input valid, input start_index, input none_found, output ready);
endinterface

// Register write channel
interface qwd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [qwd_pkg::CFG_IDX_BITS-1:0]  index;
    logic [qwd_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/qwd_cmp_unit.sv =====
// Shared compare unit: one less-or-equal test, operands picked by operation.
// Depends on qwd_pkg (cmp_req_t, cmp_op_t, widths).
module qwd_cmp_unit (
    input  qwd_pkg::cmp_req_t req,
    output logic              le
);

    logic [qwd_pkg::CMP_BITS-1:0] opa;
    logic [qwd_pkg::CMP_BITS-1:0] opb;
    logic [qwd_pkg::SUM_BITS-1:0] lo_plus_thr;

    // Minimum plus threshold for the window range test
    assign lo_plus_thr = qwd_pkg::SUM_BITS'(req.entry_b.val)
                       + qwd_pkg::SUM_BITS'(req.threshold);

    // Operand select
    always_comb
    begin
        case (req.op)
            qwd_pkg::CMP_EXPIRE:
            begin
                opa = qwd_pkg::CMP_BITS'(req.entry_a.pos);
                opb = qwd_pkg::CMP_BITS'(req.cut);
            end
            qwd_pkg::CMP_DROP_MAX:
            begin
                opa = qwd_pkg::CMP_BITS'(req.entry_a.val);
                opb = qwd_pkg::CMP_BITS'(req.sample);
            end
            qwd_pkg::CMP_DROP_MIN:
            begin
                opa = qwd_pkg::CMP_BITS'(req.sample);
                opb = qwd_pkg::CMP_BITS'(req.entry_a.val);
            end
            qwd_pkg::CMP_RANGE:
            begin
                // max - min <= thr  is  max <= min + thr
                opa = qwd_pkg::CMP_BITS'(req.entry_a.val);
                opb = qwd_pkg::CMP_BITS'(lo_plus_thr);
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign le = (opa <= opb);

endmodule

// ===== hdl/quiet_window_detector.sv =====
// Quiet window detector: sliding max/min over window_len samples, reports quiet windows.
// One sample at a time: after acceptance, each deque in turn expires entries at or before
// the cut, drops dominated tail entries and appends the sample; then come the range test and
// hand-off. Each entry drops once. The result is registered at hand-off; a saturated position
// goes straight to hand-off. Hand-off waits while an older result is untaken.
// Reset (rst_n low, async): pointers, counts, position, flags cleared; window_len=1, threshold=0.
module quiet_window_detector (
    input  logic         clk,
    input  logic         rst_n,
    qwd_sample_if.sink   samples,
    qwd_result_if.source results,
    qwd_cfg_if.sink      cfg
);

    localparam logic [qwd_pkg::INDEX_BITS-1:0] POS_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXP_RD,
        S_EXP_CMP,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_WRITE,
        S_HEAD_RD,
        S_HEAD_CMP,
        S_DONE
    } state_t;

    // Wrapping pointer steps
    function automatic logic [qwd_pkg::PTR_BITS-1:0] ptr_inc(
        input logic [qwd_pkg::PTR_BITS-1:0] p);
        ptr_inc = (p == qwd_pkg::PTR_BITS'(qwd_pkg::WINDOW_MAX - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [qwd_pkg::PTR_BITS-1:0] ptr_dec(
        input logic [qwd_pkg::PTR_BITS-1:0] p);
        ptr_dec = (p == '0) ? qwd_pkg::PTR_BITS'(qwd_pkg::WINDOW_MAX - 1) : p - 1'b1;
    endfunction

    // Deque memories, index 0 = max deque, 1 = min deque
    qwd_pkg::entry_t max_mem [qwd_pkg::WINDOW_MAX];
    qwd_pkg::entry_t min_mem [qwd_pkg::WINDOW_MAX];
    qwd_pkg::entry_t max_rd_reg;
    qwd_pkg::entry_t min_rd_reg;
    logic [qwd_pkg::PTR_BITS-1:0] max_raddr;
    logic [qwd_pkg::PTR_BITS-1:0] min_raddr;
    logic                         mem_we;
    qwd_pkg::entry_t              wr_entry;

    // Control and payload state
    state_t                          state_reg, state_next;
    logic                            sel_reg, sel_next;
    logic [qwd_pkg::PTR_BITS-1:0]    head_reg [2];
    logic [qwd_pkg::PTR_BITS-1:0]    head_next [2];
    logic [qwd_pkg::PTR_BITS-1:0]    tail_reg [2];
    logic [qwd_pkg::PTR_BITS-1:0]    tail_next [2];
    logic [qwd_pkg::CNT_BITS-1:0]    cnt_reg [2];
    logic [qwd_pkg::CNT_BITS-1:0]    cnt_next [2];
    logic [qwd_pkg::INDEX_BITS-1:0]  pos_reg, pos_next;
    logic                            any_reg, any_next;
    logic [qwd_pkg::SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                            last_reg, last_next;
    logic [qwd_pkg::INDEX_BITS-1:0]  cut_reg, cut_next;
    logic [qwd_pkg::INDEX_BITS-1:0]  start_reg, start_next;
    logic                            expire_reg, expire_next;
    logic                            check_reg, check_next;
    logic                            res_reg, res_next;
    logic                            res_none_reg, res_none_next;
    logic                            out_valid_reg, out_valid_next;
    logic [qwd_pkg::INDEX_BITS-1:0]  out_start_reg, out_start_next;
    logic                            out_none_reg, out_none_next;
    logic [qwd_pkg::WLEN_BITS-1:0]   wlen_reg;
    logic [qwd_pkg::THR_BITS-1:0]    thr_reg;

    // Shared compare unit
    qwd_pkg::cmp_req_t cmp_req;
    logic              cmp_le;

    qwd_cmp_unit u_cmp (
        .req (cmp_req),
        .le  (cmp_le)
    );

    // Effective window length, clamped to 1..WINDOW_MAX
    logic [qwd_pkg::WLEN_BITS-1:0]  win_len;
    logic [qwd_pkg::INDEX_BITS-1:0] win_len_ext;
    logic [qwd_pkg::INDEX_BITS-1:0] pos_inc;

    assign win_len = (wlen_reg == '0) ? qwd_pkg::WLEN_BITS'(1) :
                     (wlen_reg > qwd_pkg::WLEN_BITS'(qwd_pkg::WINDOW_MAX)) ?
                     qwd_pkg::WLEN_BITS'(qwd_pkg::WINDOW_MAX) : wlen_reg;
    assign win_len_ext = qwd_pkg::INDEX_BITS'(win_len);
    assign pos_inc     = pos_reg + 1'b1;

    // Handshakes
    assign samples.ready       = (state_reg == S_IDLE);
    assign cfg.ready           = 1'b1;
    assign results.valid       = out_valid_reg;
    assign results.start_index = out_start_reg;
    assign results.none_found  = out_none_reg;

    // Compare operands
    always_comb
    begin
        cmp_req.entry_a   = sel_reg ? min_rd_reg : max_rd_reg;
        cmp_req.entry_b   = min_rd_reg;
        cmp_req.sample    = sample_reg;
        cmp_req.cut       = cut_reg;
        cmp_req.threshold = thr_reg;
        case (state_reg)
            S_PUSH_CMP: cmp_req.op = sel_reg ? qwd_pkg::CMP_DROP_MIN : qwd_pkg::CMP_DROP_MAX;
            S_HEAD_CMP:
            begin
                cmp_req.op      = qwd_pkg::CMP_RANGE;
                cmp_req.entry_a = max_rd_reg;
            end
            default:    cmp_req.op = qwd_pkg::CMP_EXPIRE;
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        any_next       = any_reg;
        sample_next    = sample_reg;
        last_next      = last_reg;
        cut_next       = cut_reg;
        start_next     = start_reg;
        expire_next    = expire_reg;
        check_next     = check_reg;
        res_next       = res_reg;
        res_none_next  = res_none_reg;
        out_start_next = out_start_reg;
        out_none_next  = out_none_reg;
        out_valid_next = out_valid_reg & ~results.ready;
        max_raddr      = head_reg[0];
        min_raddr      = head_reg[1];
        mem_we         = 1'b0;
        wr_entry.val   = sample_reg;
        wr_entry.pos   = pos_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (samples.valid)
                begin
                    sample_next   = samples.sample;
                    last_next     = samples.last_sample;
                    res_next      = 1'b0;
                    res_none_next = 1'b0;
                    sel_next      = 1'b0;
                    if (pos_reg != POS_MAX)
                    begin
                        pos_next    = pos_inc;
                        cut_next    = pos_inc - win_len_ext;
                        start_next  = pos_inc - win_len_ext + 1'b1;
                        expire_next = (pos_inc > win_len_ext);
                        check_next  = (pos_inc >= win_len_ext);
                        state_next  = S_EXP_RD;
                    end
                    else
                    begin
                        // saturated position: only the end of recording is handled
                        state_next = S_DONE;
                    end
                end
            end

            // Expire entries at or before the cut from the head
            S_EXP_RD:
            begin
                if (sel_reg)
                    min_raddr = head_reg[1];
                else
                    max_raddr = head_reg[0];
                if (!expire_reg || cnt_reg[sel_reg] == '0)
                    state_next = S_PUSH_RD;
                else
                    state_next = S_EXP_CMP;
            end

            S_EXP_CMP:
            begin
                if (cmp_le)
                begin
                    head_next[sel_reg] = ptr_inc(head_reg[sel_reg]);
                    cnt_next[sel_reg]  = cnt_reg[sel_reg] - 1'b1;
                    state_next         = S_EXP_RD;
                end
                else
                begin
                    state_next = S_PUSH_RD;
                end
            end

            // Prune dominated entries from the tail
            S_PUSH_RD:
            begin
                if (sel_reg)
                    min_raddr = ptr_dec(tail_reg[1]);
                else
                    max_raddr = ptr_dec(tail_reg[0]);
                if (cnt_reg[sel_reg] == '0)
                    state_next = S_WRITE;
                else
                    state_next = S_PUSH_CMP;
            end

            S_PUSH_CMP:
            begin
                if (cmp_le)
                begin
                    tail_next[sel_reg] = ptr_dec(tail_reg[sel_reg]);
                    cnt_next[sel_reg]  = cnt_reg[sel_reg] - 1'b1;
                    state_next         = S_PUSH_RD;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end

            // Append the new sample
            S_WRITE:
            begin
                mem_we             = 1'b1;
                tail_next[sel_reg] = ptr_inc(tail_reg[sel_reg]);
                cnt_next[sel_reg]  = cnt_reg[sel_reg] + 1'b1;
                if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = S_EXP_RD;
                end
                else if (check_reg)
                begin
                    state_next = S_HEAD_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Read both heads, then test the window range
            S_HEAD_RD:
            begin
                max_raddr  = head_reg[0];
                min_raddr  = head_reg[1];
                state_next = S_HEAD_CMP;
            end

            S_HEAD_CMP:
            begin
                if (cmp_le)
                begin
                    res_next = 1'b1;
                    any_next = 1'b1;
                end
                state_next = S_DONE;
            end

            // Hand off the result and close the recording on the last sample
            S_DONE:
            begin
                if (last_reg && !any_reg && !res_reg)
                begin
                    res_next      = 1'b1;
                    res_none_next = 1'b1;
                end
                if (!(res_next && out_valid_reg && !results.ready))
                begin
                    if (res_next)
                    begin
                        out_valid_next = 1'b1;
                        out_none_next  = res_none_next;
                        out_start_next = res_none_next ? '0 : start_reg;
                    end
                    if (last_reg)
                    begin
                        pos_next     = '0;
                        any_next     = 1'b0;
                        head_next[0] = '0;
                        head_next[1] = '0;
                        tail_next[0] = '0;
                        tail_next[1] = '0;
                        cnt_next[0]  = '0;
                        cnt_next[1]  = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= 1'b0;
            head_reg[0]   <= '0;
            head_reg[1]   <= '0;
            tail_reg[0]   <= '0;
            tail_reg[1]   <= '0;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            pos_reg       <= '0;
            any_reg       <= 1'b0;
            last_reg      <= 1'b0;
            expire_reg    <= 1'b0;
            check_reg     <= 1'b0;
            res_reg       <= 1'b0;
            res_none_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wlen_reg      <= qwd_pkg::WLEN_BITS'(1);
            thr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            any_reg       <= any_next;
            last_reg      <= last_next;
            expire_reg    <= expire_next;
            check_reg     <= check_next;
            res_reg       <= res_next;
            res_none_reg  <= res_none_next;
            out_valid_reg <= out_valid_next;
            // register writes
            if (cfg.valid)
            begin
                if (cfg.index == qwd_pkg::REG_WINDOW_LEN)
                    wlen_reg <= cfg.data[qwd_pkg::WLEN_BITS-1:0];
                else if (cfg.index == qwd_pkg::REG_THRESHOLD)
                    thr_reg <= cfg.data[qwd_pkg::THR_BITS-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        cut_reg       <= cut_next;
        start_reg     <= start_next;
        out_start_reg <= out_start_next;
        out_none_reg  <= out_none_next;
    end

    // Max deque memory
    always_ff @(posedge clk)
    begin
        if (mem_we && !sel_reg)
            max_mem[tail_reg[0]] <= wr_entry;
        max_rd_reg <= max_mem[max_raddr];
    end

    // Min deque memory
    always_ff @(posedge clk)
    begin
        if (mem_we && sel_reg)
            min_mem[tail_reg[1]] <= wr_entry;
        min_rd_reg <= min_mem[min_raddr];
    end

endmodule
